// ===== design/utd_pkg.sv =====
`default_nettype none

package utd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;
    localparam logic [15:0] SURR_HI_BASE   = 16'hD7C0;
    localparam logic [15:0] SURR_LO_BASE   = 16'hDC00;
    localparam logic [15:0] CAP_RESET      = 16'hFFFF;

    typedef enum logic [1:0] {
        OC_OK       = 2'd0,
        OC_INVALID  = 2'd1,
        OC_OVERFLOW = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [15:0] utf16_word;
        logic        unit_valid;
        logic        string_done;
        outcome_t    outcome;
    } result_t;

    typedef struct packed {
        logic [1:0] n_res;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] len;
        unique casez (b)
            8'b0???????: len = 3'd1;
            8'b10??????: len = 3'd0;
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            8'b111110??: len = 3'd5;
            8'b1111110?: len = 3'd6;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [31:0] magic_sub(input logic [2:0] len);
        logic [31:0] m;
        case (len)
            3'd2:    m = 32'h0000_3080;
            3'd3:    m = 32'h000E_2080;
            3'd4:    m = 32'h03C8_2080;
            3'd5:    m = 32'hFA08_2080;
            3'd6:    m = 32'h8208_2080;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] shortest_min(input logic [2:0] len);
        logic [31:0] m;
        case (len)
            3'd2:    m = 32'h0000_0080;
            3'd3:    m = 32'h0000_0800;
            3'd4:    m = 32'h0001_0000;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/utd_decode.sv =====
`default_nettype none

module utd_decode
    import utd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        step,
    input  wire logic [7:0]  byte_in,
    input  wire logic        last_in,
    output dec_out_t         dec
);

    logic [15:0] cap_reg;
    logic [31:0] acc_reg,  acc_next;
    logic [2:0]  exp_reg,  exp_next;
    logic [2:0]  seen_reg, seen_next;
    logic        bad_reg,  bad_next;
    logic        four_reg, four_next;
    logic [16:0] uw_reg,   uw_next;
    logic        disc_reg, disc_next;

    logic [2:0]  lead_len;
    logic [31:0] acc_shift;
    logic [2:0]  seen_inc;
    logic [31:0] cp;
    logic        do_fail;
    logic        do_clear;
    outcome_t    fail_oc;
    logic [17:0] uw_plus2;

    assign lead_len  = seq_length(byte_in);
    assign acc_shift = {acc_reg[25:0], 6'b0} + {24'b0, byte_in};
    assign seen_inc  = seen_reg + 3'd1;
    assign cp        = acc_shift - magic_sub(exp_reg);
    assign uw_plus2  = {1'b0, uw_reg} + 18'd2;

    always_comb
    begin
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        seen_next = seen_reg;
        bad_next  = bad_reg;
        four_next = four_reg;
        uw_next   = uw_reg;
        disc_next = disc_reg;
        dec       = '0;
        do_fail   = 1'b0;
        do_clear  = 1'b0;
        fail_oc   = OC_OK;

        if (disc_reg)
        begin
            if (last_in)
            begin
                do_clear  = 1'b1;
                disc_next = 1'b0;
            end
        end
        else if (exp_reg == 3'd0)
        begin
            if (uw_reg >= {1'b0, cap_reg})
            begin
                do_fail = 1'b1;
                fail_oc = OC_OVERFLOW;
            end
            else if (lead_len == 3'd0)
            begin
                do_fail = 1'b1;
                fail_oc = OC_INVALID;
            end
            else if (lead_len == 3'd1)
            begin
                dec.n_res                = 2'd1;
                dec.res0.utf16_word      = {8'b0, byte_in};
                dec.res0.unit_valid      = 1'b1;
                dec.res0.string_done     = last_in;
                uw_next                  = uw_reg + 17'd1;
                do_clear                 = last_in;
            end
            else
            begin
                acc_next  = {24'b0, byte_in};
                exp_next  = lead_len;
                seen_next = 3'd1;
                bad_next  = 1'b0;
                four_next = (lead_len == 3'd4);
                if (last_in)
                begin
                    do_fail = 1'b1;
                    fail_oc = OC_INVALID;
                end
            end
        end
        else
        begin
            bad_next  = bad_reg | (byte_in[7:6] != 2'b10);
            acc_next  = acc_shift;
            seen_next = seen_inc;
            if (seen_inc < exp_reg)
            begin
                if (last_in)
                begin
                    do_fail = 1'b1;
                    fail_oc = OC_INVALID;
                end
            end
            else
            begin
                acc_next  = '0;
                exp_next  = '0;
                seen_next = '0;
                if (bad_next || (cp > MAX_CODE_POINT) || (exp_reg >= 3'd5) ||
                    (cp < shortest_min(exp_reg)))
                begin
                    do_fail = 1'b1;
                    fail_oc = OC_INVALID;
                end
                else if (four_reg)
                begin
                    four_next = 1'b0;
                    if (uw_plus2 > {2'b0, cap_reg})
                    begin
                        do_fail = 1'b1;
                        fail_oc = OC_OVERFLOW;
                    end
                    else
                    begin
                        dec.n_res            = 2'd2;
                        dec.res0.utf16_word  = SURR_HI_BASE + {5'b0, cp[20:10]};
                        dec.res0.unit_valid  = 1'b1;
                        dec.res1.utf16_word  = SURR_LO_BASE + {6'b0, cp[9:0]};
                        dec.res1.unit_valid  = 1'b1;
                        dec.res1.string_done = last_in;
                        uw_next              = uw_plus2[16:0];
                        do_clear             = last_in;
                    end
                end
                else
                begin
                    dec.n_res            = 2'd1;
                    dec.res0.utf16_word  = cp[15:0];
                    dec.res0.unit_valid  = 1'b1;
                    dec.res0.string_done = last_in;
                    uw_next              = uw_reg + 17'd1;
                    do_clear             = last_in;
                end
            end
        end

        // error: one done result, then drop bytes up to the end of the string
        if (do_fail)
        begin
            dec.n_res            = 2'd1;
            dec.res0             = '0;
            dec.res0.string_done = 1'b1;
            dec.res0.outcome     = fail_oc;
            do_clear             = 1'b1;
            disc_next            = !last_in;
        end

        if (do_clear)
        begin
            acc_next  = '0;
            exp_next  = '0;
            seen_next = '0;
            bad_next  = 1'b0;
            four_next = 1'b0;
            uw_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            exp_reg  <= '0;
            seen_reg <= '0;
            bad_reg  <= 1'b0;
            four_reg <= 1'b0;
            uw_reg   <= '0;
            disc_reg <= 1'b0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
            bad_reg  <= bad_next;
            four_reg <= four_next;
            uw_reg   <= uw_next;
            disc_reg <= disc_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/utf8_to_utf16_decoder.sv =====
// channel   dir  tdata                tuser                        tlast
// s_axis    in   [7:0] byte_in        -                            last_byte
// m_axis    out  [15:0] utf16_word    [0] unit_valid, [2:1] outcome string_done
// cfg       in   cfg_data [15:0] unit_capacity, written when cfg_we is high
//
// one byte per cycle in while s_tready is high, one result per cycle out while
// m_tready is high; a four-byte sequence gives two results; m_tvalid follows
// an input transaction through the input register, then the four-entry result queue
// reset clears all string state and sets unit_capacity to 65535
// s_tready drops only while a byte waits for room, i.e. while more than two
// results would remain queued after the current output transaction
`default_nettype none

module utf8_to_utf16_decoder
    import utd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] utf16_word
    output logic [7:0]       m_tuser,   // [0] unit_valid, [2:1] outcome, [7:3] zero
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);

    logic                in_vld_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;

    result_t             q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;

    logic                pop;
    logic                room;
    logic                consume;
    logic [QUEUE_AW:0]   push_n;
    dec_out_t            dec;
    result_t             head;

    assign pop      = m_tvalid && m_tready;
    assign room     = (cnt_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2)) ||
                      ((cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH - 1)) && pop);
    assign consume  = in_vld_reg && room;
    assign s_tready = !in_vld_reg || consume;
    assign push_n   = consume ? (QUEUE_AW+1)'(dec.n_res) : '0;
    assign cnt_next = cnt_reg - (QUEUE_AW+1)'(pop) + push_n;

    utd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step     (consume),
        .byte_in  (in_byte_reg),
        .last_in  (in_last_reg),
        .dec      (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && (dec.n_res != 2'd0))
        begin
            q_reg[wr_ptr_reg] <= dec.res0;
        end
        if (consume && (dec.n_res == 2'd2))
        begin
            q_reg[wr_ptr_reg + QUEUE_AW'(1)] <= dec.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n[QUEUE_AW-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = head.utf16_word;
    assign m_tuser  = {5'b0, head.outcome, head.unit_valid};
    assign m_tlast  = head.string_done;

endmodule

`default_nettype wire

// ===== design/utd_checker.sv =====
`default_nettype none

module utd_checker
    import utd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [7:0]  m_tuser,
    input wire logic        m_tlast
);

    // nothing to deliver while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result shown during reset");

    // an outcome only on the closing result of a string
    a_outcome_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == OC_OK))
        else $error("outcome set on a result that does not close the string");

    // a result without a unit is an error that ends the string
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
        (m_tlast && (m_tdata == 16'h0000) &&
         ((m_tuser[2:1] == OC_INVALID) || (m_tuser[2:1] == OC_OVERFLOW))))
        else $error("malformed error result");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind utf8_to_utf16_decoder utd_checker u_utd_checker (.*);

`default_nettype wire
